@@ design/bdq_pkg.sv @@
// Shared constants, types and ring-index helpers for the bounded deque.
package bdq_pkg;

  // Ring size and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 4;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SORT       = 3'd5;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SORT_FIRST,
    ST_SORT_RUN,
    ST_SORT_TAIL
  } state_t;

  // Write request into the word store.
  typedef struct packed {
    logic                     en;
    logic [PTR_W-1:0]         addr;
    logic signed [WORD_W-1:0] data;
  } mem_wr_t;

  // Physical slot of the word at index idx from the front.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [PTR_W-1:0] idx);
    logic [PTR_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Ring step forward.
  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Ring step backward.
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

@@ design/bdq_store.sv @@
// Word store of the deque: one write port and one registered read port.
module bdq_store (
  input  logic                              clk,
  input  bdq_pkg::mem_wr_t                  wr,
  input  logic                              rd_en,
  input  logic [bdq_pkg::PTR_W-1:0]         rd_addr,
  output logic signed [bdq_pkg::WORD_W-1:0] rd_data
);
  import bdq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/bounded_deque_with_sort.sv @@
// Top level of the bounded deque: request controller, pointers and result register.
//
// Requests enter on the in_ channel (in_valid / in_stall) and each one yields
// exactly one result word on the out_ channel (out_valid / out_stall): the ok
// flag, the read word and the count after the request.
// Pushes, pops and failing requests finish in the cycle they are accepted; the
// result is visible on the next cycle. A read goes through the store's
// registered read port and then the result register. A sort runs bubble passes
// over the store, one compare per cycle through the single read and write port,
// and up to count passes run.
// Sorting zero or one word finishes at once.
// One request is in flight at a time; a new one is accepted as soon as the
// controller is idle and the result register is empty or being drained, so
// simple requests run back to back at one per cycle while the receiver keeps up.
// Reset clears the head pointer, the count and all control state; the word
// store is not cleared and needs no clearing pass. When the receiver stalls,
// the result word holds and in_stall rises until it has been taken.
module bounded_deque_with_sort (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdq_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_push_value,
  input  logic [bdq_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic signed [bdq_pkg::WORD_W-1:0] out_read_data,
  output logic [bdq_pkg::CNT_W-1:0]         out_count
);
  import bdq_pkg::*;

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [PTR_W-1:0]         idx_r, idx_nxt;
  logic signed [WORD_W-1:0] cur_r, cur_nxt;
  logic                     swapped_r, swapped_nxt;

  logic                     out_valid_r;
  logic                     out_ok_r;
  logic signed [WORD_W-1:0] out_read_data_r;
  logic [CNT_W-1:0]         out_count_r;

  logic                     out_load;
  logic                     res_ok;
  logic signed [WORD_W-1:0] res_data;

  mem_wr_t                  wr;
  logic                     rd_en;
  logic [PTR_W-1:0]         rd_addr;
  logic signed [WORD_W-1:0] rd_data;

  logic                     out_free;
  logic                     in_acc;
  logic                     not_full;
  logic                     not_empty;
  logic [PTR_W-1:0]         last_idx;

  bdq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake on the request side.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign not_full  = (fill_r < CNT_W'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign last_idx  = PTR_W'(fill_r - CNT_W'(1));

  // Next state, store accesses and result selection.
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    swapped_nxt = swapped_r;
    wr          = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    out_load    = 1'b0;
    res_ok      = 1'b0;
    res_data    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_PUSH_BACK: begin
              out_load = 1'b1;
              if (not_full) begin
                wr.en    = 1'b1;
                wr.addr  = slot_of(head_r, PTR_W'(fill_r));
                wr.data  = in_push_value;
                fill_nxt = fill_r + CNT_W'(1);
                res_ok   = 1'b1;
              end
            end
            REQ_PUSH_FRONT: begin
              out_load = 1'b1;
              if (not_full) begin
                head_nxt = ring_dec(head_r);
                wr.en    = 1'b1;
                wr.addr  = ring_dec(head_r);
                wr.data  = in_push_value;
                fill_nxt = fill_r + CNT_W'(1);
                res_ok   = 1'b1;
              end
            end
            REQ_POP_BACK: begin
              out_load = 1'b1;
              if (not_empty) begin
                fill_nxt = fill_r - CNT_W'(1);
                res_ok   = 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              out_load = 1'b1;
              if (not_empty) begin
                head_nxt = ring_inc(head_r);
                fill_nxt = fill_r - CNT_W'(1);
                res_ok   = 1'b1;
              end
            end
            REQ_READ: begin
              if (CNT_W'(in_position) < fill_r) begin
                rd_en     = 1'b1;
                rd_addr   = slot_of(head_r, PTR_W'(in_position));
                state_nxt = ST_RD_WAIT;
              end else begin
                out_load = 1'b1;
              end
            end
            REQ_SORT: begin
              if (fill_r > CNT_W'(1)) begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = ST_SORT_FIRST;
              end else begin
                out_load = 1'b1;
                res_ok   = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // Read data arrives from the store.
      ST_RD_WAIT: begin
        out_load  = 1'b1;
        res_ok    = 1'b1;
        res_data  = rd_data;
        state_nxt = ST_IDLE;
      end

      // First word of a pass becomes the running maximum.
      ST_SORT_FIRST: begin
        cur_nxt     = rd_data;
        swapped_nxt = 1'b0;
        idx_nxt     = PTR_W'(1);
        rd_en       = 1'b1;
        rd_addr     = slot_of(head_r, PTR_W'(1));
        state_nxt   = ST_SORT_RUN;
      end

      // Compare the running maximum with the next word and settle one slot.
      ST_SORT_RUN: begin
        wr.en   = 1'b1;
        wr.addr = slot_of(head_r, idx_r - PTR_W'(1));
        if (cur_r > rd_data) begin
          wr.data     = rd_data;
          swapped_nxt = 1'b1;
        end else begin
          wr.data = cur_r;
          cur_nxt = rd_data;
        end
        if (idx_r == last_idx) begin
          state_nxt = ST_SORT_TAIL;
        end else begin
          idx_nxt = idx_r + PTR_W'(1);
          rd_en   = 1'b1;
          rd_addr = slot_of(head_r, idx_r + PTR_W'(1));
        end
      end

      // Write the pass maximum to the back; run another pass if anything moved.
      ST_SORT_TAIL: begin
        wr.en   = 1'b1;
        wr.addr = slot_of(head_r, last_idx);
        wr.data = cur_r;
        if (swapped_r) begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = ST_SORT_FIRST;
        end else begin
          out_load  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      fill_r    <= '0;
      swapped_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      swapped_r <= swapped_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // Running maximum of a sort pass.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Result register toward the out_ channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r        <= res_ok;
      out_read_data_r <= res_data;
      out_count_r     <= fill_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_read_data = out_read_data_r;
  assign out_count     = out_count_r;

  // The count never exceeds the ring size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("deque count exceeds ring size");

  // A new result is never loaded over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result word overwritten while stalled");

  // While a read or a sort is in flight no result word is pending.
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending during a multi-cycle request");

  // A push into a ring with room grows the count by one.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && not_full &&
     (in_req_type == REQ_PUSH_BACK || in_req_type == REQ_PUSH_FRONT))
    |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("push did not grow the count");

  // A sort leaves the count unchanged while its compare steps run.
  a_sort_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT_RUN) |=> (fill_r == $past(fill_r)))
    else $error("count changed during a sort");

endmodule

@@ tb/sv/tb_bounded_deque_with_sort.sv @@
// Self-checking testbench for the bounded deque with sort: request stimulus, result checks.
module tb_bounded_deque_with_sort;
  import bdq_pkg::*;

  // Request codes the block treats as no-ops.
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  // Even with every word a sort, stalls and gaps, the slowest correct run stays
  // well under this cycle limit.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_WORDS   = 300;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 20;

  // One request word and its pacing for the sender and receiver.
  typedef struct {
    logic [REQ_W-1:0]         req;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         pos;
    int                       tx_idle;
    int                       rx_stall;
    bit                       wait_drain;
    int                       hold_cycles;
  } req_word_t;

  // One result word.
  typedef struct {
    logic                     ok;
    logic signed [WORD_W-1:0] data;
    logic [CNT_W-1:0]         count;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = '0;
  logic signed [WORD_W-1:0] in_push_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic signed [WORD_W-1:0] out_read_data;
  logic [CNT_W-1:0] out_count;

  req_word_t     req_words[$];
  deque_result_t due_results[$];

  // Handshake bookkeeping shared between the driver, receiver and monitor.
  logic word_taken = 1'b0;
  int rx_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int unsigned cycle_count = 0;
  int n_checked = 0;
  int total_words = 0;
  int fail_count = 0;

  // Stimulus generation state.
  int gen_tx = 0;
  int gen_rx = 0;
  bit gen_drain = 1'b0;
  int gen_hold = 0;
  int gen_count = 0;

  // Coverage tallies for the summary.
  int n_push = 0;
  int n_pop = 0;
  int n_read = 0;
  int n_sort = 0;
  int n_spare = 0;
  int n_refused = 0;
  int n_full = 0;
  int n_empty = 0;

  // Predicted deque contents.
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int ring_head = 0;
  int ring_fill = 0;

  bounded_deque_with_sort u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_push_value(in_push_value),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_read_data(out_read_data),
    .out_count    (out_count)
  );

  always #6 clk = ~clk;

  // Apply one request to the predicted deque and return the result word it should give.
  function automatic deque_result_t deque_outcome(input logic [REQ_W-1:0] req,
                                                  input logic signed [WORD_W-1:0] value,
                                                  input logic [POS_W-1:0] pos);
    deque_result_t r;
    logic signed [WORD_W-1:0] t;
    int a;
    int b;
    bit swapped;
    r.ok = 1'b0;
    r.data = '0;
    case (req)
      REQ_PUSH_BACK: begin
        if (ring_fill < DEPTH) begin
          ring_words[(ring_head + ring_fill) % DEPTH] = value;
          ring_fill++;
          r.ok = 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (ring_fill < DEPTH) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_words[ring_head] = value;
          ring_fill++;
          r.ok = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (ring_fill > 0) begin
          ring_fill--;
          r.ok = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (ring_fill > 0) begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
          r.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (int'(pos) < ring_fill) begin
          r.data = ring_words[(ring_head + int'(pos)) % DEPTH];
          r.ok = 1'b1;
        end
      end
      REQ_SORT: begin
        // Bubble passes in signed order until a pass makes no swap.
        swapped = 1'b1;
        while (swapped) begin
          swapped = 1'b0;
          for (int i = 0; i + 1 < ring_fill; i++) begin
            a = (ring_head + i) % DEPTH;
            b = (ring_head + i + 1) % DEPTH;
            if (ring_words[a] > ring_words[b]) begin
              t = ring_words[a];
              ring_words[a] = ring_words[b];
              ring_words[b] = t;
              swapped = 1'b1;
            end
          end
        end
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(ring_fill);
    return r;
  endfunction

  // Random push value, weighted toward the extremes and toward small repeats.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return WORD_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Queue one request word with the current pacing.
  task automatic add_word(input logic [REQ_W-1:0] req, input logic signed [WORD_W-1:0] value,
                          input logic [POS_W-1:0] pos);
    req_word_t w;
    w.req = req;
    w.value = value;
    w.pos = pos;
    w.tx_idle = gen_tx;
    w.rx_stall = gen_rx;
    w.wait_drain = gen_drain;
    w.hold_cycles = gen_hold;
    gen_drain = 1'b0;
    gen_hold = 0;
    req_words.insert(req_words.size(), w);
    if (req <= REQ_SORT) begin
      gen_count++;
    end
  endtask

  // Driver: offer the next word at the falling edge; hold it until it is taken.
  always @(negedge clk) begin : drive_words
    req_word_t next_word;
    if (rst_n && !(in_valid && !word_taken)) begin
      if (req_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (req_words[0].wait_drain && due_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) < req_words[0].tx_idle) begin
        in_valid <= 1'b0;
      end else begin
        next_word = req_words[0];
        req_words.delete(0);
        in_valid <= 1'b1;
        in_req_type <= next_word.req;
        in_push_value <= next_word.value;
        in_position <= next_word.pos;
        word_taken <= 1'b0;
        rx_pct <= next_word.rx_stall;
        if (next_word.hold_cycles > 0) begin
          hold_len <= next_word.hold_cycles;
          hold_seq <= hold_seq + 1;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold when the driver asks for one.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // Monitor: predict on each accepted request word, then check each accepted result word.
  always @(posedge clk) begin : watch_words
    deque_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = deque_outcome(in_req_type, in_push_value, in_position);
        due_results.insert(due_results.size(), want);
        word_taken <= 1'b1;
        case (in_req_type)
          REQ_PUSH_BACK, REQ_PUSH_FRONT: n_push++;
          REQ_POP_BACK, REQ_POP_FRONT: n_pop++;
          REQ_READ: n_read++;
          REQ_SORT: n_sort++;
          default: n_spare++;
        endcase
        if (!want.ok) begin
          n_refused++;
        end
        if (want.count == CNT_W'(DEPTH)) begin
          n_full++;
        end
        if (want.count == '0) begin
          n_empty++;
        end
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result word arrived with no request outstanding");
          fail_count++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          n_checked <= n_checked + 1;
          if (out_ok !== want.ok) begin
            $error("out_ok mismatch: expected %0d, actual %0d", want.ok, out_ok);
            fail_count++;
          end
          if (out_read_data !== want.data) begin
            $error("out_read_data mismatch: expected %0d, actual %0d", want.data,
                   out_read_data);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("out_count mismatch: expected %0d, actual %0d", want.count, out_count);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_bounded_deque_with_sort failed");
      $finish;
    end
  end

  // Build the request list, release reset, then wait for every result word.
  initial begin
    int tx_mix [4];
    int rx_mix [4];
    int phase_start;
    int burst;
    int len;
    tx_mix = '{0, 74, 0, 17};
    rx_mix = '{0, 0, 74, 17};

    // Directed opening: refusals on an empty deque, spare codes, extremes and sorts.
    add_word(REQ_POP_BACK, 0, 0);
    add_word(REQ_POP_FRONT, -1, 15);
    add_word(REQ_READ, 0, 0);
    add_word(REQ_READ, 0, 15);
    add_word(REQ_SORT, 0, 0);
    add_word(REQ_SPARE_A, 32'sh7FFF_FFFF, 15);
    add_word(REQ_SPARE_B, 32'sh8000_0000, 0);
    add_word(REQ_PUSH_BACK, 5, 0);
    add_word(REQ_SORT, 0, 0);
    add_word(REQ_PUSH_BACK, 32'sh7FFF_FFFF, 0);
    add_word(REQ_PUSH_FRONT, 32'sh8000_0000, 0);
    add_word(REQ_PUSH_BACK, 0, 0);
    add_word(REQ_PUSH_FRONT, -1, 0);
    add_word(REQ_READ, 0, 0);
    add_word(REQ_READ, 0, 5);
    add_word(REQ_SORT, 0, 0);
    for (int i = 0; i < 5; i++) begin
      add_word(REQ_READ, 0, POS_W'(i));
    end
    add_word(REQ_POP_BACK, 0, 0);
    add_word(REQ_POP_FRONT, 0, 0);
    add_word(REQ_POP_BACK, 0, 0);
    add_word(REQ_POP_FRONT, 0, 0);
    add_word(REQ_POP_FRONT, 0, 0);
    add_word(REQ_POP_BACK, 0, 0);

    // Random bursts in four pacing mixes.
    for (int ph = 0; ph < 4; ph++) begin
      gen_tx = tx_mix[ph];
      gen_rx = rx_mix[ph];
      // Later mixes start only once the deque has answered everything so far.
      gen_drain = (ph != 0);
      if (ph == 0) begin
        // Long receiver hold while pushes keep coming, so the input backs up.
        gen_hold = LONG_HOLD;
        repeat (DEPTH + 4) begin
          add_word($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_word(),
                   POS_W'($urandom));
        end
      end
      phase_start = gen_count;
      while (gen_count - phase_start < PHASE_WORDS) begin
        burst = $urandom_range(0, 9);
        len = $urandom_range(1, DEPTH + 2);
        case (burst)
          0, 1, 2: begin
            repeat (len) begin
              add_word($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_word(),
                       POS_W'($urandom));
            end
          end
          3, 4: begin
            repeat (len) begin
              add_word($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_word(),
                       POS_W'($urandom));
            end
          end
          5, 6: begin
            repeat (len / 2 + 1) begin
              add_word(REQ_READ, pick_word(), POS_W'($urandom));
            end
          end
          7: begin
            // Sort, then read the front in order.
            add_word(REQ_SORT, pick_word(), POS_W'($urandom));
            for (int i = 0; i < len && i < DEPTH; i++) begin
              add_word(REQ_READ, pick_word(), POS_W'(i));
            end
          end
          default: begin
            repeat ($urandom_range(1, 6)) begin
              add_word(REQ_W'($urandom_range(0, 7)), pick_word(), POS_W'($urandom));
            end
          end
        endcase
      end
    end
    total_words = req_words.size();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (n_checked < total_words) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d result words never arrived", due_results.size());
      fail_count++;
    end

    $display("%0d requests in four pacing mixes: %0d push, %0d pop, %0d read, %0d sort, %0d spare.",
             total_words, n_push, n_pop, n_read, n_sort, n_spare);
    $display("%0d requests were refused; the deque stood full after %0d and empty after %0d.",
             n_refused, n_full, n_empty);
    if (fail_count == 0) begin
      $display("tb_bounded_deque_with_sort passed");
    end else begin
      $display("tb_bounded_deque_with_sort failed");
    end
    $finish;
  end

endmodule
